[hw/rtl/base64_stream_codec_top_assert.svh]
// ============================================================================
// Base64 stream codec assertion macros
// Shared immediate-implication and next-cycle checks, clocked on clk and
// disabled while rst_n is low.
// ============================================================================
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define B64SC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 codec check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define B64SC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 codec check failed");

`endif

[hw/rtl/b64sc_pkg.sv]
// ============================================================================
// Base64 stream codec package
// Shared types, constants and alphabet functions.
// ============================================================================
package b64sc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int SLOTS       = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        SK_CHAR = 2'd0,   // alphabet character, val holds the sextet
        SK_PAD  = 2'd1,   // '=' padding
        SK_DATA = 2'd2,   // decoded byte
        SK_MARK = 2'd3    // bare end marker
    } slot_kind_t;

    typedef struct packed {
        slot_kind_t kind;
        logic [7:0] val;
    } slot_t;

    typedef struct packed {
        slot_t [SLOTS-1:0] slots;
        logic [1:0]        cnt_m1;   // number of results minus one
        logic              last;     // entry closes the string
        logic              inval;    // decoding stopped at a bad character
    } entry_t;

    // Map a sextet to its alphabet character.
    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      char_of = 8'h41 + w;
        else if (v < 6'd52) char_of = 8'h61 + w - 8'd26;
        else if (v < 6'd62) char_of = 8'h30 + w - 8'd52;
        else if (v == 6'd62) char_of = 8'h2B;
        else                 char_of = 8'h2F;
    endfunction

    // Map a character to {miss, sextet}; miss set outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      sextet_of = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A) sextet_of = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39) sextet_of = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)               sextet_of = {1'b0, 6'd62};
        else if (c == 8'h2F)               sextet_of = {1'b0, 6'd63};
        else                               sextet_of = {1'b1, 6'd0};
    endfunction

endpackage

[hw/rtl/b64sc_front.sv]
// ============================================================================
// Base64 stream codec front end
// Accepts input items, tracks the string state and builds queue entries.
// ============================================================================
module b64sc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output b64sc_pkg::entry_t q_data
);
    import b64sc_pkg::*;

    logic [11:0] acc_reg,  acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic [1:0]  mod_reg,  mod_next;
    logic        stop_reg, stop_next;
    logic        mode_reg, mode_next;
    logic        inside_reg, inside_next;

    logic        accept;
    logic        mode;
    logic [11:0] acc0, acc1;
    logic [3:0]  p0, p1, p2;
    logic [1:0]  m0, m1, pads;
    logic        stop0;
    logic [5:0]  c1, c2, tail;
    logic [1:0]  nchar;
    logic [2:0]  total;
    logic [5:0]  ch [3];
    logic [6:0]  sx;
    logic [3:0]  dshift;
    logic        emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode  = inside_reg ? mode_reg : func;
        acc0  = inside_reg ? acc_reg  : 12'd0;
        p0    = inside_reg ? pend_reg : 4'd0;
        m0    = inside_reg ? mod_reg  : 2'd0;
        stop0 = inside_reg ? stop_reg : 1'b0;

        acc_next    = acc0;
        pend_next   = p0;
        mod_next    = m0;
        stop_next   = stop0;
        mode_next   = mode;
        inside_next = !in_last;

        q_push = 1'b0;
        q_data = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            q_data.slots[i].kind = SK_PAD;
            q_data.slots[i].val  = 8'd0;
        end
        q_data.last = in_last;

        acc1   = 12'd0;
        p1     = 4'd0;
        p2     = 4'd0;
        m1     = 2'd0;
        pads   = 2'd0;
        c1     = 6'd0;
        c2     = 6'd0;
        tail   = 6'd0;
        nchar  = 2'd0;
        total  = 3'd0;
        sx     = 7'd0;
        dshift = 4'd0;
        emit   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ch[i] = 6'd0;
        end

        if (!mode)
        begin
            // Encode: shift in eight bits, drain sextets.
            acc1 = {acc0[3:0], in_byte};
            p1   = p0 + 4'd8;
            c1   = 6'(acc1 >> (p1 - 4'd6));
            c2   = acc1[5:0];
            p2   = (p1 == 4'd12) ? 4'd0 : p1 - 4'd6;
            case (p2)
                4'd2:    tail = {acc1[1:0], 4'b0000};
                4'd4:    tail = {acc1[3:0], 2'b00};
                default: tail = 6'd0;
            endcase
            nchar = 2'd1 + ((p1 == 4'd12) ? 2'd1 : 2'd0)
                  + ((in_last && p2 != 4'd0) ? 2'd1 : 2'd0);
            m1    = m0 + nchar;
            pads  = in_last ? 2'(-m1) : 2'd0;
            total = {1'b0, nchar} + {1'b0, pads};
            ch[0] = c1;
            ch[1] = (p1 == 4'd12) ? c2 : tail;
            ch[2] = tail;
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < nchar)
                begin
                    q_data.slots[i].kind = SK_CHAR;
                    q_data.slots[i].val  = {2'b00, ch[i]};
                end
            end
            q_data.cnt_m1 = 2'(total - 3'd1);
            q_push        = accept;

            acc_next  = acc1;
            pend_next = in_last ? 4'd0 : p2;
            mod_next  = in_last ? 2'd0 : m1;
        end
        else
        begin
            // Decode: gather six bits per character, yield a byte at eight.
            sx = sextet_of(in_byte);
            if (!stop0)
            begin
                if (sx[6])
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    acc1   = {acc0[5:0], sx[5:0]};
                    p1     = p0 + 4'd6;
                    dshift = p1 - 4'd8;
                    emit   = (p1 >= 4'd8);
                    acc_next  = acc1;
                    pend_next = emit ? dshift : p1;
                end
            end
            q_data.cnt_m1 = 2'd0;
            if (emit)
            begin
                q_data.slots[0].kind = SK_DATA;
                q_data.slots[0].val  = 8'(acc1 >> dshift);
            end
            else
            begin
                q_data.slots[0].kind = SK_MARK;
                q_data.inval         = stop_next;
            end
            q_push = accept && (emit || in_last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pend_reg   <= '0;
            mod_reg    <= '0;
            stop_reg   <= 1'b0;
            mode_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            mod_reg    <= mod_next;
            stop_reg   <= stop_next;
            mode_reg   <= mode_next;
            inside_reg <= inside_next;
        end
    end

endmodule

[hw/rtl/b64sc_queue.sv]
// ============================================================================
// Base64 stream codec entry queue
// Small FIFO of result entries between the front and back ends.
// ============================================================================
`include "base64_stream_codec_top_assert.svh"

module b64sc_queue #(
    parameter int Depth = b64sc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64sc_pkg::entry_t push_data,
    output logic              full,
    output logic              head_valid,
    output b64sc_pkg::entry_t head_data,
    input  logic              pop
);
    import b64sc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    entry_t          mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64SC_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CntW'(Depth))
    `B64SC_ASSERT_NOW(a_no_overflow, full, !push)
    `B64SC_ASSERT_NOW(a_no_underflow, !head_valid, !pop)
    `B64SC_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

[hw/rtl/b64sc_back.sv]
// ============================================================================
// Base64 stream codec back end
// Walks the head entry one slot per cycle into the output register, while that register is empty or being taken.
// ============================================================================
`include "base64_stream_codec_top_assert.svh"

module b64sc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64sc_pkg::entry_t head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              out_last,
    output logic              hit_invalid
);
    import b64sc_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;
    logic       inval_reg, inval_next;

    slot_t      cur;
    logic       final_slot;
    logic       load;

    assign cur        = head_data.slots[idx_reg];
    assign final_slot = (idx_reg == head_data.cnt_m1);
    assign load       = head_valid && (!valid_reg || out_ready);
    assign pop        = load && final_slot;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        inval_next = inval_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = final_slot ? 2'd0 : idx_reg + 2'd1;
            has_next   = (cur.kind != SK_MARK);
            last_next  = head_data.last && final_slot;
            inval_next = head_data.inval && final_slot;
            case (cur.kind)
                SK_CHAR: byte_next = char_of(cur.val[5:0]);
                SK_PAD:  byte_next = PAD_CHAR;
                SK_DATA: byte_next = cur.val;
                default: byte_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        has_reg   <= has_next;
        last_reg  <= last_next;
        inval_reg <= inval_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign out_last    = last_reg;
    assign hit_invalid = inval_reg;

    `B64SC_ASSERT_NOW(a_marker_is_last, valid_reg && !has_reg, last_reg)
    `B64SC_ASSERT_NOW(a_invalid_on_marker, valid_reg && inval_reg, last_reg && !has_reg)
    `B64SC_ASSERT_NOW(a_idx_idle, !head_valid, idx_reg == 2'd0)

endmodule

[hw/rtl/base64_stream_codec_top.sv]
// ============================================================================
// Base64 stream codec, top level
// The first result of a request is written to the queue and then to the output
// register before it appears, when the queue and the output register are empty.
// One result per cycle while out_ready allows; an encode request yields 1 to 4
// results (about 4/3 per byte plus padding), a decode request 0 or 1. The
// two-entry queue takes no request while full, even in a cycle that pops it.
// Reset (rst_n, async, active low) clears the queue, output stage and string state.
// ============================================================================
module base64_stream_codec_top #(
    parameter int QueueDepth = b64sc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    // input request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    output logic       hit_invalid
);
    import b64sc_pkg::*;

    // Front to queue: one entry per request that yields results.
    logic   q_push;
    logic   q_full;
    entry_t q_in;

    // Queue to back end: head entry, dropped after its final slot goes out.
    logic   q_valid;
    logic   q_pop;
    entry_t q_head;

    // Front end: latch the mode at string start, advance the bit
    // accumulator and classify the request into one queue entry.
    b64sc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Queue: decouple front and back so either side may stall.
    b64sc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop)
    );

    // Back end: map sextets to characters, padding slots to '=' and pass decoded bytes, and hold each
    // result in the output register until taken.
    b64sc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_data   (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .out_last    (out_last),
        .hit_invalid (hit_invalid)
    );

endmodule
